@@ rtl/gradient_threshold_edge_detect_macros.svh @@
// assertion helpers for the edge detector
`ifndef GRADIENT_THRESHOLD_EDGE_DETECT_MACROS_SVH
`define GRADIENT_THRESHOLD_EDGE_DETECT_MACROS_SVH

// same-cycle implication, checked on the rising clock outside reset
`define GTED_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("edge detect check failed");

// next-cycle implication, checked on the rising clock outside reset
`define GTED_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("edge detect check failed");

`endif

@@ rtl/gted_pkg.sv @@
package gted_pkg;

  // geometry limits and field widths
  localparam int unsigned MaxCols = 2048;
  localparam int unsigned ColW    = $clog2(MaxCols);
  localparam int unsigned ColsW   = 12;
  localparam int unsigned RowW    = 16;
  localparam int unsigned GreenW  = 8;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned LimitW  = 18;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned OutW    = RowW + ColW + LevelW;
  localparam int unsigned OutTdW  = ((OutW + 7) / 8) * 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFrameCols = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameRows = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEdgeLimit = 2'd2;

  // register reset values
  localparam logic [ColsW-1:0]  FrameColsRst = 12'd640;
  localparam logic [RowW-1:0]   FrameRowsRst = 16'd480;
  localparam logic [LimitW-1:0] EdgeLimitRst = 18'd400;

  // output levels
  localparam logic [LevelW-1:0] LevelEdge = 8'd0;
  localparam logic [LevelW-1:0] LevelFlat = 8'd255;

  // item waiting for its results after the store read
  typedef struct packed {
    logic              has_prev;
    logic              last_row;
    logic              interior;
    logic              parity;
    logic [RowW-1:0]   row;
    logic [RowW-1:0]   prev_row;
    logic [ColW-1:0]   col;
    logic [GreenW-1:0] green;
  } s1_info_t;

  // one result item
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic              last;
  } result_t;

endpackage

@@ rtl/gradient_threshold_edge_detect.sv @@
// Central-difference edge detector on the green channel of a raster pixel stream.
// One pixel is accepted every clock cycle unless the output stalls; each arriving pixel
// classifies the pixel one row above it, so results trail the input by one row and pass
// through the store read, then the output register. Inputs of the first row give no
// result, inputs of the last row give two, so during the last row the single output
// register takes both results of a pixel before the next pixel is accepted. Two row banks of
// 2048 x 8 bits, each with one write and two read ports, hold the previous two rows; the
// pixel written and the older value read at the same column share one edge, read before
// write. Border pixels come out as 255, edges as 0. Configure frame_cols, frame_rows and
// edge_limit only while the block is idle.
`include "gradient_threshold_edge_detect_macros.svh"

module gradient_threshold_edge_detect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gted_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gted_pkg::LimitW-1:0]   cfg_data_i,
  // pixel input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gted_pkg::GreenW-1:0]   s_axis_tdata,  // green
  // result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [gted_pkg::OutTdW-1:0]   m_axis_tdata,  // out_row, out_col, out_level, pad
  output logic                          m_axis_tlast   // last_of_run
);
  import gted_pkg::*;

  // configuration registers
  logic [ColsW-1:0]  frame_cols_q;
  logic [RowW-1:0]   frame_rows_q;
  logic [LimitW-1:0] edge_limit_q;

  // position counters
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  // row banks and their read data
  logic [GreenW-1:0] mem0_q [MaxCols];
  logic [GreenW-1:0] mem1_q [MaxCols];
  logic [GreenW-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;

  // item stage and output register
  s1_info_t s1_info_q, s1_info_d;
  logic     s1_valid_q, s1_valid_d;
  logic     s1_sel_q, s1_sel_d;
  result_t  out_q, out_d;
  logic     out_valid_q, out_valid_d;

  logic             accept;
  logic [ColsW-1:0] cols_eff;
  logic [RowW-1:0]  rows_eff;
  logic [ColsW-1:0] col_next;
  logic [RowW:0]    row_next;
  logic             last_col, last_row, interior;
  logic [ColW-1:0]  addr_c, addr_l, addr_r, addr0a, addr1a;

  logic                     first_pend, has_res, is_final, out_free, emit, s1_done;
  logic [GreenW-1:0]        center, left, right;
  logic signed [GreenW:0]   dx, dy;
  logic signed [2*GreenW+1:0] dx_sq, dy_sq;
  logic [LimitW-1:0]        grad_sq;
  logic [LevelW-1:0]        level;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cols_q <= FrameColsRst;
      frame_rows_q <= FrameRowsRst;
      edge_limit_q <= EdgeLimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFrameCols: frame_cols_q <= cfg_data_i[ColsW-1:0];
        CfgFrameRows: frame_rows_q <= cfg_data_i[RowW-1:0];
        CfgEdgeLimit: edge_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    if (frame_cols_q == '0) begin
      cols_eff = ColsW'(1);
    end else if (frame_cols_q > ColsW'(MaxCols)) begin
      cols_eff = ColsW'(MaxCols);
    end else begin
      cols_eff = frame_cols_q;
    end
    rows_eff = (frame_rows_q < RowW'(2)) ? RowW'(2) : frame_rows_q;
  end

  // position flags of the incoming pixel
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign col_next = {1'b0, col_q} + ColsW'(1);
  assign row_next = {1'b0, row_q} + (RowW + 1)'(1);
  assign last_col = col_next >= cols_eff;
  assign last_row = row_next >= {1'b0, rows_eff};
  assign interior = (row_q >= RowW'(2)) && (col_q != '0) && (col_next < cols_eff);

  // counter update
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_next[RowW-1:0];
      end else begin
        col_d = col_next[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // bank addresses: the current-row bank reads the column, the other its neighbors
  assign addr_c = col_q;
  assign addr_l = col_q - ColW'(1);
  assign addr_r = col_q + ColW'(1);
  assign addr0a = row_q[0] ? addr_l : addr_c;
  assign addr1a = row_q[0] ? addr_c : addr_l;

  // bank for even rows
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd0a_q <= mem0_q[addr0a];
      rd0b_q <= mem0_q[addr_r];
      if (!row_q[0]) begin
        mem0_q[addr_c] <= s_axis_tdata;
      end
    end
  end

  // bank for odd rows
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd1a_q <= mem1_q[addr1a];
      rd1b_q <= mem1_q[addr_r];
      if (row_q[0]) begin
        mem1_q[addr_c] <= s_axis_tdata;
      end
    end
  end

  // item info captured with the read
  always_comb begin
    s1_info_d          = s1_info_q;
    s1_info_d.has_prev = row_q != '0;
    s1_info_d.last_row = last_row;
    s1_info_d.interior = interior;
    s1_info_d.parity   = row_q[0];
    s1_info_d.row      = row_q;
    s1_info_d.prev_row = row_q - RowW'(1);
    s1_info_d.col      = col_q;
    s1_info_d.green    = s_axis_tdata;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= s1_info_d;
    end
  end

  // gradient and threshold
  assign center  = s1_info_q.parity ? rd1a_q : rd0a_q;
  assign left    = s1_info_q.parity ? rd0a_q : rd1a_q;
  assign right   = s1_info_q.parity ? rd0b_q : rd1b_q;
  assign dx      = $signed({1'b0, right}) - $signed({1'b0, left});
  assign dy      = $signed({1'b0, s1_info_q.green}) - $signed({1'b0, center});
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;
  assign grad_sq = $unsigned(dx_sq) + $unsigned(dy_sq);
  assign level   = (s1_info_q.interior && (edge_limit_q[LimitW-1] || grad_sq > edge_limit_q))
                   ? LevelEdge : LevelFlat;

  // result sequencing: row above first, then the last-row pixel itself
  assign first_pend = s1_info_q.has_prev && !s1_sel_q;
  assign has_res    = s1_info_q.has_prev || s1_info_q.last_row;
  assign is_final   = first_pend ? !s1_info_q.last_row : 1'b1;
  assign out_free   = !out_valid_q || m_axis_tready;
  assign emit       = s1_valid_q && has_res && out_free;
  assign s1_done    = s1_valid_q && (!has_res || (out_free && is_final));

  assign s_axis_tready = !s1_valid_q || s1_done;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_sel_d   = s1_sel_q;
    if (accept) begin
      s1_valid_d = 1'b1;
      s1_sel_d   = 1'b0;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
      s1_sel_d   = 1'b0;
    end else if (emit) begin
      s1_sel_d   = 1'b1;
    end

    if (first_pend) begin
      out_d.row   = s1_info_q.prev_row;
      out_d.level = level;
    end else begin
      out_d.row   = s1_info_q.row;
      out_d.level = LevelFlat;
    end
    out_d.col  = s1_info_q.col;
    out_d.last = is_final;

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_sel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s1_sel_q    <= s1_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutTdW - OutW)'(0), out_q.level, out_q.col, out_q.row};
  assign m_axis_tlast  = out_q.last;

  // checks
  `GTED_ASSERT_IMP(a_ready_when_empty, !s1_valid_q, s_axis_tready)
  `GTED_ASSERT_IMP(a_second_only_last_row, s1_valid_q && s1_sel_q,
                   s1_info_q.last_row && s1_info_q.has_prev)
  `GTED_ASSERT_NXT(a_col_wraps, accept && last_col, col_q == '0)
  `GTED_ASSERT_IMP(a_level_code, m_axis_tvalid,
                   out_q.level == LevelEdge || out_q.level == LevelFlat)

endmodule
